FILE: hw/rtl/pwvp_pkg.sv
// ----------------------------------------------------------------------------
// pwvp_pkg: shared types and constants of the winch velocity profile
// Item types, stored segment type, divider handshake structs and codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwvp_pkg;

    // Item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // Segment control kinds
    localparam logic [1:0] CTRL_LOCKED    = 2'd0;
    localparam logic [1:0] CTRL_FREE      = 2'd1;
    localparam logic [1:0] CTRL_MOTORIZED = 2'd2;
    localparam logic [1:0] CTRL_NO_CHANGE = 2'd3;

    // Configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_WINCH_RADIUS  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'd1;

    localparam int CFG_DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [31:0] RADIUS_RESET = 32'h0001_0000;
    localparam logic [4:0]  COUNT_RESET  = 5'd1;

    // Saturation limits of a signed Q16.16 value
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Serial divider geometry: 48-bit dividend, 32-bit divisor
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic               mode;
        logic [3:0]         segment_slot;
        logic [31:0]        segment_start;
        logic [1:0]         segment_control;
        logic signed [31:0] segment_speed;
        logic signed [31:0] segment_accel;
        logic [31:0]        query_time;
    } req_item_t;

    typedef struct packed {
        logic [3:0]         active_segment;
        logic [1:0]         drive_control;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0]        start;
        logic [1:0]         kind;
        logic signed [31:0] speed;
        logic signed [31:0] accel;
    } seg_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
        logic [DIV_DEN_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: hw/rtl/pwvp_seg_mem.sv
// ----------------------------------------------------------------------------
// pwvp_seg_mem: segment table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwvp_seg_mem
    import pwvp_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  seg_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output seg_entry_t        rd_data
);

    seg_entry_t mem [DEPTH];
    seg_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/pwvp_divider.sv
// ----------------------------------------------------------------------------
// pwvp_divider: unsigned restoring divider
// One quotient bit per cycle; done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwvp_divider
    import pwvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : DIV_DEN_W'(trial);
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hw/rtl/piecewise_winch_velocity_profile.sv
// A write item gives no result. An evaluate item scans 0 .. count-1 table
// entries, one per table read, then fetches the active segment. A motorized
// segment then goes through multiply, round, add and saturate, and unless the
// radius is zero a division on the 48-step serial divider and a rounding step.
// Throughput: one item at a time; the next item is taken once the last is done.
// Reset: radius 1.0, one segment, table undefined.
// ----------------------------------------------------------------------------
// piecewise_winch_velocity_profile: segment table with velocity evaluation
// Write items load a segment into the table memory. Evaluate items scan the
// table for the active segment, then compute v + a*(t - t0) and v / radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_winch_velocity_profile
    import pwvp_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_en,
    input  logic [REG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // item channel
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req,
    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_item_t             rsp
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    // Controller states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_FETCH = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_SUM   = 4'd4;
    localparam logic [3:0] ST_SPEED = 4'd5;
    localparam logic [3:0] ST_DIVS  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_ROUND = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] radius_reg;
    logic [4:0]  seg_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RESET;
            seg_count_reg <= COUNT_RESET;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_WINCH_RADIUS:  radius_reg    <= cfg_data[31:0];
                REG_SEGMENT_COUNT: seg_count_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    logic [3:0]          state_reg, state_next;
    logic [31:0]         time_reg, time_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    sel_reg, sel_next;
    logic [1:0]          kind_reg, kind_next;
    logic signed [31:0]  speed_reg, speed_next;
    logic [31:0]         mag_a_reg, mag_a_next;
    logic [31:0]         mag_dt_reg, mag_dt_next;
    logic                neg_reg, neg_next;
    logic [63:0]         prod_reg, prod_next;
    logic [48:0]         r_reg, r_next;
    logic signed [31:0]  lin_reg, lin_next;
    logic signed [31:0]  ang_reg, ang_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg, rsp_next;

    // memory and divider hookup
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    seg_entry_t          mem_wr_data;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    seg_entry_t          mem_rd_data;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // combinational helpers
    logic                req_fire;
    logic [CNT_W-1:0]    cnt_eff;
    logic [IDX_W-1:0]    last_eff;
    logic [32:0]         dt;
    logic [32:0]         dt_neg_val;
    logic [64:0]         round_sum;
    logic [50:0]         r_wide;
    logic signed [50:0]  v_wide;
    logic                v_ovf;
    logic [31:0]         mag_v;
    logic                round_up;
    logic [48:0]         q_round;
    logic [31:0]         q_neg;

    assign req_fire = req_valid && req_ready;

    // Clamp the segment count into 1 .. MAX_SEGMENTS
    always_comb
    begin
        if (seg_count_reg == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (32'(seg_count_reg) > MAX_SEGMENTS)
        begin
            cnt_eff = CNT_W'(MAX_SEGMENTS);
        end
        else
        begin
            cnt_eff = CNT_W'(seg_count_reg);
        end
        last_eff = IDX_W'(cnt_eff - CNT_W'(1));
    end

    // Write items go straight to the table; slots beyond the table drop
    assign mem_wr_en   = req_fire && (req.mode == MODE_WRITE) &&
                         (32'(req.segment_slot) < MAX_SEGMENTS);
    assign mem_wr_addr = IDX_W'(req.segment_slot);
    assign mem_wr_data = '{start: req.segment_start,
                           kind:  req.segment_control,
                           speed: req.segment_speed,
                           accel: req.segment_accel};

    // Time offset from the segment start, signed 33 bits, and its magnitude
    assign dt         = {1'b0, time_reg} - {1'b0, mem_rd_data.start};
    assign dt_neg_val = ~dt + 33'd1;

    // Round the Q32.32 product to Q16.16, ties away from zero
    assign round_sum = {1'b0, prod_reg} + 65'h8000;
    assign r_wide    = {2'b00, r_reg};

    // Start speed plus the signed increment, then detect overflow of 32 bits
    assign v_wide = 51'(speed_reg) + (neg_reg ? -$signed(r_wide) : $signed(r_wide));
    assign v_ovf  = !((&v_wide[50:31]) || !(|v_wide[50:31]));

    assign mag_v = lin_reg[31] ? (~lin_reg + 32'd1) : lin_reg;

    // Round the quotient to nearest: bump it when 2*rem >= radius
    assign round_up = ({div_rsp.remainder, 1'b0} >= {1'b0, radius_reg});
    assign q_round  = {1'b0, div_rsp.quotient} + 49'(round_up);
    assign q_neg    = ~q_round[31:0] + 32'd1;

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        sel_next       = sel_reg;
        kind_next      = kind_reg;
        speed_next     = speed_reg;
        mag_a_next     = mag_a_reg;
        mag_dt_next    = mag_dt_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        r_next         = r_reg;
        lin_next       = lin_reg;
        ang_next       = ang_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        div_req        = '{start: 1'b0, dividend: {mag_v, 16'h0000}, divisor: radius_reg};

        // drop the held result once it is taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.mode == MODE_EVAL))
                begin
                    time_next = req.query_time;
                    last_next = last_eff;
                    mem_rd_en = 1'b1;
                    if (last_eff == '0)
                    begin
                        // single segment in use: fetch segment 0 directly
                        sel_next    = '0;
                        mem_rd_addr = '0;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        idx_next    = IDX_W'(1);
                        mem_rd_addr = IDX_W'(1);
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // start time of entry idx is in hand
                mem_rd_en = 1'b1;
                if (time_reg < mem_rd_data.start)
                begin
                    sel_next    = idx_reg - IDX_W'(1);
                    mem_rd_addr = idx_reg - IDX_W'(1);
                    state_next  = ST_FETCH;
                end
                else if (idx_reg == last_reg)
                begin
                    sel_next    = last_reg;
                    mem_rd_addr = last_reg;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    idx_next    = idx_reg + IDX_W'(1);
                    mem_rd_addr = idx_reg + IDX_W'(1);
                end
            end

            ST_FETCH:
            begin
                kind_next   = mem_rd_data.kind;
                speed_next  = mem_rd_data.speed;
                mag_a_next  = mem_rd_data.accel[31] ? (~mem_rd_data.accel + 32'd1)
                                                    : mem_rd_data.accel;
                mag_dt_next = dt[32] ? dt_neg_val[31:0] : dt[31:0];
                neg_next    = mem_rd_data.accel[31] ^ dt[32];
                if (mem_rd_data.kind == CTRL_MOTORIZED)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    lin_next   = '0;
                    ang_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_MUL:
            begin
                prod_next  = mag_a_reg * mag_dt_reg;
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                r_next     = round_sum[64:16];
                state_next = ST_SPEED;
            end

            ST_SPEED:
            begin
                if (v_ovf)
                begin
                    lin_next = v_wide[50] ? SAT_MIN : SAT_MAX;
                end
                else
                begin
                    lin_next = v_wide[31:0];
                end
                state_next = ST_DIVS;
            end

            ST_DIVS:
            begin
                if (radius_reg == '0)
                begin
                    // no drum radius: saturate toward the sign of the speed
                    if (lin_reg == '0)
                    begin
                        ang_next = '0;
                    end
                    else
                    begin
                        ang_next = lin_reg[31] ? SAT_MIN : SAT_MAX;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                if (lin_reg[31])
                begin
                    ang_next = (q_round > 49'h0_8000_0000) ? SAT_MIN : q_neg;
                end
                else
                begin
                    ang_next = (q_round > 49'h0_7FFF_FFFF) ? SAT_MAX : q_round[31:0];
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next = '{active_segment: 4'(sel_reg),
                                 drive_control:  kind_reg,
                                 linear_speed:   lin_reg,
                                 angular_speed:  ang_reg};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        sel_reg    <= sel_next;
        kind_reg   <= kind_next;
        speed_reg  <= speed_next;
        mag_a_reg  <= mag_a_next;
        mag_dt_reg <= mag_dt_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        r_reg      <= r_next;
        lin_reg    <= lin_next;
        ang_reg    <= ang_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Segment table and divider
    // ------------------------------------------------------------------
    pwvp_seg_mem #(
        .DEPTH  (MAX_SEGMENTS),
        .ADDR_W (IDX_W)
    ) u_seg_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pwvp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

FILE: dv/tb_piecewise_winch_velocity_profile.sv
// ----------------------------------------------------------------------------
// tb_piecewise_winch_velocity_profile: self-checking bench of the velocity profile
// Loads segments and evaluates the profile at chosen and random times. An
// in-bench predictor tracks the table and the registers, so every result is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piecewise_winch_velocity_profile;
    import pwvp_pkg::*;

    localparam int          TABLE_DEPTH = 16;
    localparam int unsigned IDLE_PCT    = 9;    // idle cycles per hundred, each side
    localparam int          ITEMS_PER_SETTING = 59;
    localparam int          SETTINGS_RUN      = 7;
    localparam int unsigned WRITE_PCT   = 30;   // share of write items in random traffic
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_AFTER  = 200;  // results seen before the long hold-off
    localparam int          HOLD_CYCLES = 400;
    localparam logic [31:0] STEP        = 32'h0010_0000; // 16 s between ladder starts

    // Clock, reset and block inputs, all known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_en    = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_item_t             req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_item_t             rsp;

    // Bench state
    req_item_t   pending_items[$];
    rsp_item_t   expected_profile[$];
    seg_entry_t  seg_table[TABLE_DEPTH];
    logic [31:0] radius_q = RADIUS_RESET;
    logic [4:0]  seg_count = COUNT_RESET;
    int          issued_cnt = 0;
    int          accepted_cnt = 0;
    int          results_checked = 0;
    int          err_count = 0;
    int          n_writes = 0;
    int          n_evals = 0;
    int          settings_used = 0;
    bit          calm = 1'b0;       // no idling on either side while set
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    piecewise_winch_velocity_profile #(
        .MAX_SEGMENTS(TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sat_q16(longint v);
        if (v > longint'(SAT_MAX))
            return longint'(SAT_MAX);
        if (v < longint'(SAT_MIN))
            return longint'(SAT_MIN);
        return v;
    endfunction

    // Select the active segment for time t and work out both speeds
    function automatic rsp_item_t predict_profile(logic [31:0] t);
        int          n;
        int          sel;
        int          i;
        bit          found;
        bit          neg;
        seg_entry_t  seg;
        longint      dt;
        longint      a;
        longint      v;
        longint      w;
        longint      rv;
        logic [63:0] prod;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] rem;
        rsp_item_t   res;

        n = seg_count;
        if (n == 0)
            n = 1;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        sel = n - 1;
        found = 1'b0;
        for (i = 1; i < n; i++)
        begin
            if (!found && t < seg_table[i].start)
            begin
                sel = i - 1;
                found = 1'b1;
            end
        end
        seg = seg_table[sel];
        res.active_segment = sel[3:0];
        res.drive_control  = seg.kind;
        res.linear_speed   = '0;
        res.angular_speed  = '0;
        if (seg.kind == CTRL_MOTORIZED)
        begin
            dt = longint'({32'd0, t}) - longint'({32'd0, seg.start});
            a  = longint'(seg.accel);
            neg = (a < 0) != (dt < 0);
            prod = mag64(a) * mag64(dt);
            rv = longint'((prod + 64'h8000) >> 16);   // round half away from zero
            v = sat_q16(longint'(seg.speed) + (neg ? -rv : rv));
            if (radius_q == 0)
                w = (v > 0) ? longint'(SAT_MAX) : ((v < 0) ? longint'(SAT_MIN) : 0);
            else
            begin
                num = mag64(v) << 16;
                den = {32'd0, radius_q};
                q   = num / den;
                rem = num % den;
                if (rem >= den - rem)
                    q = q + 1;
                w = sat_q16((v < 0) ? -longint'(q) : longint'(q));
            end
            res.linear_speed  = v[31:0];
            res.angular_speed = w[31:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_write(logic [3:0] slot, logic [31:0] start, logic [1:0] kind,
                              logic signed [31:0] speed, logic signed [31:0] accel);
        req_item_t it;
        it = '0;
        it.mode            = MODE_WRITE;
        it.segment_slot    = slot;
        it.segment_start   = start;
        it.segment_control = kind;
        it.segment_speed   = speed;
        it.segment_accel   = accel;
        pending_items.push_back(it);
    endtask

    task automatic push_eval(logic [31:0] t);
        req_item_t it;
        it = '0;
        it.mode       = MODE_EVAL;
        it.query_time = t;
        pending_items.push_back(it);
    endtask

    // Mostly small Q16.16 values (within +-16) so rounding and division show;
    // the rest span the full range and exercise saturation.
    function automatic logic signed [31:0] pick_q16();
        logic signed [31:0] x;
        if ($urandom_range(99) < 60)
        begin
            x = $urandom_range(32'h001F_FFFF);
            x = x - 32'sh0010_0000;
        end
        else
            x = $urandom;
        return x;
    endfunction

    // Start and query times mostly cluster around a ladder of segment starts
    function automatic logic [31:0] pick_time(logic [3:0] slot);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return slot * STEP + $urandom_range(32'h000F_FFFF);
        if (r < 75)
            return slot * STEP;
        return $urandom;
    endfunction

    function automatic req_item_t pick_item();
        req_item_t it;
        it = $urandom;   // noise in every field first
        it.segment_start = $urandom;
        it.segment_speed = $urandom;
        it.segment_accel = $urandom;
        it.query_time    = $urandom;
        it.mode = ($urandom_range(99) < WRITE_PCT) ? MODE_WRITE : MODE_EVAL;
        it.segment_slot = $urandom_range(TABLE_DEPTH - 1);
        if (it.mode == MODE_WRITE)
        begin
            it.segment_start   = pick_time(it.segment_slot);
            it.segment_control = ($urandom_range(9) < 5) ? CTRL_MOTORIZED
                                                          : 2'($urandom_range(3));
            it.segment_speed   = pick_q16();
            it.segment_accel   = pick_q16();
        end
        else
            it.query_time = pick_time(4'($urandom_range(TABLE_DEPTH - 1)));
        return it;
    endfunction

    // Write one register while the block is idle; mirror it in the predictor
    task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_en   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_en <= 1'b0;
        if (idx == REG_WINCH_RADIUS)
            radius_q = value;
        else
            seg_count = value[4:0];
        @(posedge clk);
    endtask

    // Drain everything in flight, then let the block settle
    task automatic wait_idle();
        while (pending_items.size() != 0 || issued_cnt != accepted_cnt ||
               expected_profile.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h (result %0d)",
                 field, got, want, results_checked);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer pending items at the falling edge, hold until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (accepted_cnt == issued_cnt)
        begin
            // previous item taken (or none offered): advance or idle
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                req <= pending_items.pop_front();
                req_valid <= 1'b1;
                issued_cnt++;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && results_checked >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, then update the predictor with accepted items
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_profile.size() == 0)
                begin
                    report_mismatch("result with none expected", rsp.linear_speed, 32'd0);
                end
                else
                begin
                    want = expected_profile.pop_front();
                    if (rsp.active_segment !== want.active_segment)
                        report_mismatch("active_segment", 32'(rsp.active_segment),
                                        32'(want.active_segment));
                    if (rsp.drive_control !== want.drive_control)
                        report_mismatch("drive_control", 32'(rsp.drive_control),
                                        32'(want.drive_control));
                    if (rsp.linear_speed !== want.linear_speed)
                        report_mismatch("linear_speed", rsp.linear_speed, want.linear_speed);
                    if (rsp.angular_speed !== want.angular_speed)
                        report_mismatch("angular_speed", rsp.angular_speed,
                                        want.angular_speed);
                end
                results_checked++;
            end
            if (req_valid && req_ready)
            begin
                if (req.mode == MODE_WRITE)
                begin
                    seg_table[req.segment_slot] = '{req.segment_start, req.segment_control,
                                                    req.segment_speed, req.segment_accel};
                    n_writes++;
                end
                else
                begin
                    expected_profile.push_back(predict_profile(req.query_time));
                    n_evals++;
                end
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] rad;
        logic [31:0] cnt;
        int          ph;
        int          k;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: one segment, radius 1.0
        push_write(4'd0, 32'd0, CTRL_MOTORIZED, 32'sd0, 32'sh0001_0000);
        push_eval(32'd0);                       // zero elapsed time
        push_eval(32'hFFFF_FFFF);               // longest time, positive overflow
        push_write(4'd0, 32'hFFFF_FFFF, CTRL_MOTORIZED, SAT_MAX, SAT_MAX);
        push_eval(32'd0);                       // most negative elapsed time
        push_write(4'd0, 32'd0, CTRL_MOTORIZED, SAT_MIN, SAT_MIN);
        push_eval(32'hFFFF_FFFF);               // negative overflow
        push_write(4'd0, 32'd0, CTRL_MOTORIZED, 32'sd0, 32'sd1);
        push_eval(32'h0000_8000);               // half an lsb rounds up
        push_write(4'd0, 32'd0, CTRL_MOTORIZED, 32'sd0, -32'sd1);
        push_eval(32'h0000_8000);               // and away from zero when negative
        push_write(4'd0, 32'd0, CTRL_LOCKED, 32'sd5, 32'sd7);
        push_eval(32'h0001_0000);
        push_write(4'd0, 32'd0, CTRL_FREE, 32'sd5, 32'sd7);
        push_eval(32'h0001_0000);
        push_write(4'd0, 32'd0, CTRL_NO_CHANGE, 32'sd5, 32'sd7);
        push_eval(32'h0001_0000);

        // Fill the whole table on a ladder so no evaluation reads an unwritten entry
        for (k = 0; k < TABLE_DEPTH; k++)
            push_write(4'(k), k * STEP, 2'(k % 4), pick_q16(), pick_q16());
        wait_idle();
        cfg_write(REG_SEGMENT_COUNT, 32'd16);
        cfg_write(REG_WINCH_RADIUS, 32'h0001_8000);
        push_eval(3 * STEP);                    // exactly at a start time
        push_eval(3 * STEP - 1);                // just before it
        push_eval(32'd0);
        push_eval(32'hFFFF_FFFF);               // beyond the last start
        wait_idle();

        // Random traffic over several register settings, extremes included
        for (ph = 0; ph < SETTINGS_RUN; ph++)
        begin
            case (ph)
                0: begin rad = 32'h0001_0000; cnt = 16; end
                1: begin rad = 32'd1;         cnt = 16; end
                2: begin rad = 32'hFFFF_FFFF; cnt = 5;  end
                3: begin rad = 32'd0;         cnt = 3;  end
                4: begin rad = 32'h0000_8000; cnt = 0;  end   // zero count acts as one
                5: begin rad = 32'h0003_0000; cnt = 31; end   // clamps to table depth
                default: begin rad = $urandom; cnt = $urandom_range(31); end
            endcase
            cfg_write(REG_WINCH_RADIUS, rad);
            cfg_write(REG_SEGMENT_COUNT, cnt);
            settings_used++;
            calm = (ph == 2);
            for (k = 0; k < ITEMS_PER_SETTING; k++)
                pending_items.push_back(pick_item());
            wait_idle();
            calm = 1'b0;
        end

        $display("Covered %0d segment writes and %0d evaluations (%0d results checked)",
                 n_writes, n_evals, results_checked);
        $display("across %0d register settings, radius zero to full scale, counts 0 to 31",
                 settings_used + 2);
        if (err_count == 0)
            $display("tb_piecewise_winch_velocity_profile: clean");
        else
            $display("tb_piecewise_winch_velocity_profile: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d results still expected", expected_profile.size());
        $display("tb_piecewise_winch_velocity_profile: errors");
        $finish;
    end

endmodule
